### sv/bst_pkg.sv
// Shared constants and types for the bounded set table.
package bst_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 31;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture opcode and value of an accepted transaction
        logic compare;  // register the match vector
        logic commit;   // update the table and load the result registers
    } bst_cmd_t;

endpackage

### sv/bst_datapath.sv
// Datapath: entry registers, occupancy, parallel compare and result registers.
module bst_datapath #(
    parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bst_pkg::bst_cmd_t             cmd,
    input  logic [bst_pkg::OP_W-1:0]      s_opcode,
    input  logic [bst_pkg::VALUE_W-1:0]   s_value,
    output logic [bst_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_found,
    output logic [bst_pkg::COUNT_W-1:0]   m_member_count,
    output logic                          m_is_empty
);
    import bst_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [VALUE_W-1:0]  entries_reg [CAPACITY];
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [OP_W-1:0]     op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CAPACITY-1:0] match_reg;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                empty_reg;

    logic                hit;
    logic                full;
    logic [IDX_W-1:0]    slot_idx;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    wr_idx;
    logic [VALUE_W-1:0]  wr_data;
    logic                wr_en;
    logic [OCC_W-1:0]    occ_dec;
    logic [OCC_W+COUNT_W-1:0] count_ext;

    // Operand capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_opcode;
            value_reg <= s_value;
        end
    end

    // Parallel compare, only slots below occupancy take part
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= '0;
        end else if (cmd.compare) begin
            for (int i = 0; i < CAPACITY; i++) begin
                match_reg[i] <= (entries_reg[i] == value_reg) && (OCC_W'(i) < occ_reg);
            end
        end
    end

    // Members are distinct, so at most one match bit is set
    always_comb begin
        hit      = |match_reg;
        slot_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (match_reg[i]) begin
                slot_idx = slot_idx | IDX_W'(i);
            end
        end
    end

    assign full     = (occ_reg >= OCC_W'(CAPACITY));
    assign occ_dec  = occ_reg - OCC_W'(1);
    assign last_idx = occ_dec[IDX_W-1:0];

    always_comb begin
        status_next = ST_OK;
        occ_next    = occ_reg;
        wr_en       = 1'b0;
        wr_idx      = slot_idx;
        wr_data     = value_reg;
        case (op_reg)
            OP_LOOKUP: begin
                status_next = hit ? ST_OK : ST_ABSENT;
            end
            OP_INSERT: begin
                if (hit) begin
                    status_next = ST_PRESENT;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    wr_en    = 1'b1;
                    wr_idx   = occ_reg[IDX_W-1:0];
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    // swap-remove: last member moves into the freed slot
                    wr_en    = 1'b1;
                    wr_data  = entries_reg[last_idx];
                    occ_next = occ_dec;
                end else begin
                    status_next = ST_ABSENT;
                end
            end
            OP_CLEAR: begin
                occ_next = '0;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            entries_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.commit) begin
            occ_reg <= occ_next;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, occ_next};

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg <= status_next;
            found_reg  <= hit;
            count_reg  <= count_ext[COUNT_W-1:0];
            empty_reg  <= (occ_next == '0);
        end
    end

    assign m_status       = status_reg;
    assign m_found        = found_reg;
    assign m_member_count = count_reg;
    assign m_is_empty     = empty_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_reg))
        else $error("value held in more than one slot");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && op_reg == OP_INSERT && !hit && !full)
        |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("insert did not grow the set");

endmodule

### sv/bst_ctrl.sv
// Controller: sequences load, compare and commit, and owns the handshakes.
module bst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bst_pkg::bst_cmd_t cmd
);
    import bst_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       can_commit;

    assign can_commit  = !out_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE) || ((state_reg == S_UPD) && can_commit);
    assign cmd.load    = s_valid && s_ready;
    assign cmd.compare = (state_reg == S_CMP);
    assign cmd.commit  = (state_reg == S_UPD) && can_commit;
    assign m_valid     = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                // a new transaction may enter in the commit cycle
                if (can_commit) begin
                    state_next = cmd.load ? S_CMP : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed result not presented");

    a_load_compares: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.compare)
        else $error("accepted transaction not compared");

    a_no_accept_in_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> !s_ready)
        else $error("input accepted during compare");

endmodule

### sv/bounded_set_table_top.sv
// Top level of the bounded set table: controller plus datapath.
//
// A fixed-capacity set of naturals with lookup, insert, remove and clear.
// Input channel s_valid/s_ready carries s_opcode and s_value; result channel
// m_valid/m_ready carries m_status, m_found, m_member_count and m_is_empty.
// Every transaction yields exactly one result, in order.
//
// Sequence: an accepted input first has its parallel compare over all slots
// registered in the compare state, then the update state writes the table and
// loads the result register that drives m_*.
// A new transaction can be accepted while the previous one commits, unless the
// result channel stalls; compare and update share the single entry register bank.
//
// Reset (aresetn low, synchronous) empties the set and drops m_valid; entry
// contents are not cleared, slots at or above the count are never read.
// When the receiver stalls, the held result stays on m_*, one more input is
// accepted and compared, and its update waits until the held result is taken.
module bounded_set_table_top #(
    parameter int CAPACITY = bst_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bst_pkg::OP_W-1:0]      s_opcode,
    input  logic [bst_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bst_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_found,
    output logic [bst_pkg::COUNT_W-1:0]   m_member_count,
    output logic                          m_is_empty
);
    import bst_pkg::*;

    bst_cmd_t cmd;

    bst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    bst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .m_status       (m_status),
        .m_found        (m_found),
        .m_member_count (m_member_count),
        .m_is_empty     (m_is_empty)
    );

endmodule

### tb/bounded_set_table_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded set table: directed rows, then random set traffic.
module bounded_set_table_top_tb;
    import bst_pkg::*;

    localparam int CAP      = CAPACITY_DEF;
    localparam int N_RANDOM = 1075;
    localparam int POOL_N   = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } set_result_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        bit                 typed;
        set_result_t        want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode = '0;
    logic [VALUE_W-1:0]  s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic                m_found;
    logic [COUNT_W-1:0]  m_member_count;
    logic                m_is_empty;

    // Predictor state: packed members and their count
    logic [VALUE_W-1:0] model_members [CAP];
    int                 model_count = 0;

    set_result_t        pending_results[$];
    stim_row_t          stim_rows[$];
    logic [VALUE_W-1:0] value_pool [POOL_N];

    int n_sent = 0;
    int n_checked = 0;
    int n_mismatch = 0;
    int burst_left = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    bounded_set_table_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_found        (m_found),
        .m_member_count (m_member_count),
        .m_is_empty     (m_is_empty)
    );

    always #2 aclk = ~aclk;

    function automatic set_result_t mk_res(logic [STATUS_W-1:0] st, logic fnd,
                                           int cnt, logic emp);
        set_result_t r;
        r.status = st;
        r.found  = fnd;
        r.count  = cnt[COUNT_W-1:0];
        r.empty  = emp;
        return r;
    endfunction

    function automatic void add_row(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                                    bit typed, set_result_t want);
        stim_row_t row;
        row.op    = op;
        row.value = val;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endfunction

    // Applies one operation to the predictor state and returns its result
    function automatic set_result_t predict_set_op(logic [OP_W-1:0] op,
                                                   logic [VALUE_W-1:0] val);
        set_result_t r;
        int          slot;
        bit          hit;
        slot = model_count;
        for (int i = model_count - 1; i >= 0; i--) begin
            if (model_members[i] == val)
                slot = i;
        end
        hit = (slot < model_count);
        r.status = ST_OK;
        case (op)
            OP_LOOKUP: begin
                if (!hit)
                    r.status = ST_ABSENT;
            end
            OP_INSERT: begin
                if (hit) begin
                    r.status = ST_PRESENT;
                end else if (model_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    model_members[model_count] = val;
                    model_count++;
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    model_members[slot] = model_members[model_count - 1];
                    model_count--;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            default: begin
                model_count = 0;
            end
        endcase
        r.found = hit;
        r.count = model_count[COUNT_W-1:0];
        r.empty = (model_count == 0);
        return r;
    endfunction

    // Drives one transaction with bursty idling; queues its expected result on acceptance
    task automatic send_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                             bit typed, set_result_t want);
        int          gap;
        set_result_t pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= val;
        do @(posedge aclk); while (!s_ready);
        pred = predict_set_op(op, val);
        pending_results.push_back(typed ? want : pred);
        n_sent++;
    endtask

    function automatic logic [OP_W-1:0] pick_op(bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_CLEAR;
        if (filling)
            return (roll < 62) ? OP_INSERT : (roll < 85) ? OP_LOOKUP : OP_REMOVE;
        return (roll < 30) ? OP_INSERT : (roll < 50) ? OP_LOOKUP : OP_REMOVE;
    endfunction

    function automatic void refill_pool();
        for (int i = 0; i < POOL_N; i++)
            value_pool[i] = VALUE_W'($urandom);
        value_pool[0] = '0;
        value_pool[1] = '1;
    endfunction

    initial begin
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] last_fill;
        logic [OP_W-1:0]    op;
        bit                 filling;
        int                 guard;

        // Directed rows
        add_row(OP_LOOKUP, 31'd0, 1'b1, mk_res(ST_ABSENT, 1'b0, 0, 1'b1));
        add_row(OP_REMOVE, 31'd5, 1'b1, mk_res(ST_ABSENT, 1'b0, 0, 1'b1));
        add_row(OP_CLEAR, 31'd0, 1'b1, mk_res(ST_OK, 1'b0, 0, 1'b1));
        add_row(OP_INSERT, '1, 1'b1, mk_res(ST_OK, 1'b0, 1, 1'b0));
        add_row(OP_INSERT, '1, 1'b1, mk_res(ST_PRESENT, 1'b1, 1, 1'b0));
        add_row(OP_LOOKUP, '1, 1'b1, mk_res(ST_OK, 1'b1, 1, 1'b0));
        add_row(OP_INSERT, 31'd0, 1'b1, mk_res(ST_OK, 1'b0, 2, 1'b0));
        last_fill = '0;
        for (int i = 1; i <= CAP - 2; i++) begin
            last_fill = VALUE_W'(i * 31'h0912_3457) ^ 31'h2AAA_AAAA;
            add_row(OP_INSERT, last_fill, 1'b0, '0);
        end
        // presence is tested before capacity
        add_row(OP_INSERT, 31'h2AAA_AAAA, 1'b1, mk_res(ST_FULL, 1'b0, CAP, 1'b0));
        add_row(OP_INSERT, 31'd0, 1'b1, mk_res(ST_PRESENT, 1'b1, CAP, 1'b0));
        // removing slot 0 pulls the last member into it
        add_row(OP_REMOVE, '1, 1'b1, mk_res(ST_OK, 1'b1, CAP - 1, 1'b0));
        add_row(OP_LOOKUP, last_fill, 1'b0, '0);
        // clear still reports prior membership
        add_row(OP_CLEAR, 31'd0, 1'b1, mk_res(ST_OK, 1'b1, 0, 1'b1));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i])
            send_item(stim_rows[i].op, stim_rows[i].value, stim_rows[i].typed,
                      stim_rows[i].want);

        // Random traffic over a small value pool so hits, full and swaps occur
        filling = 1'b1;
        refill_pool();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 300 == 299)
                refill_pool();
            if (n % 120 == 0)
                filling = ($urandom_range(0, 2) != 0);
            op = pick_op(filling);
            if ($urandom_range(0, 99) < 88)
                v = value_pool[$urandom_range(0, POOL_N - 1)];
            else
                v = VALUE_W'($urandom);
            send_item(op, v, 1'b0, '0);
        end
        s_valid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            n_mismatch += pending_results.size();
        end

        $display("Sent %0d transactions, checked %0d results", n_sent, n_checked);
        $display("Status mix: %0d ok, %0d duplicate, %0d full, %0d absent",
                 status_seen[ST_OK], status_seen[ST_PRESENT], status_seen[ST_FULL],
                 status_seen[ST_ABSENT]);
        if (n_mismatch == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver back-pressure: a new mode is drawn whenever its random stall counter runs out
    always @(posedge aclk) begin
        static int         stall_cnt = 0;
        static int         stall_mode = 0;
        static int         mask_pos = 0;
        static logic [7:0] stall_mask = 8'hFF;
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mask = 8'($urandom);
            stall_cnt  = $urandom_range(20, 120);
        end
        stall_cnt--;
        mask_pos = (mask_pos + 1) % 8;
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 99) < 70);
            2:       m_ready <= stall_mask[mask_pos];
            default: m_ready <= ($urandom_range(0, 99) < 25);
        endcase
    end

    always @(posedge aclk) begin
        set_result_t want;
        set_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_found, m_member_count, m_is_empty};
            status_seen[m_status]++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Unexpected result transaction at %0t: %p", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("Mismatch at %0t: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                                 $realtime, want.status, want.found, want.count, want.empty,
                                 got.status, got.found, got.count, got.empty);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
